[hdl/kwl_pkg.sv]
// shared types, constants and functions for the keyword lexer
package kwl_pkg;

   localparam int NAME_BUFFER_DEF  = 9;
   localparam int STRING_LIMIT_DEF = 256;
   localparam int TABLE_DEPTH_DEF  = 256;

   // token kinds
   localparam logic [4:0] TK_INT_LIT = 5'd11;
   localparam logic [4:0] TK_STR_LIT = 5'd12;
   localparam logic [4:0] TK_KW_BASE = 5'd13;
   localparam logic [4:0] TK_IDENT   = 5'd20;
   localparam logic [4:0] TK_ERROR   = 5'd21;

   // error codes
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_UNTERM   = 3'd1;
   localparam logic [2:0] ERR_STR_LONG = 3'd2;
   localparam logic [2:0] ERR_WORD_LONG = 3'd3;
   localparam logic [2:0] ERR_BAD_BYTE = 3'd4;
   localparam logic [2:0] ERR_FULL     = 3'd5;

   // entry classes
   localparam logic [1:0] CLS_VAR  = 2'd0;
   localparam logic [1:0] CLS_FUNC = 2'd1;
   localparam logic [1:0] CLS_LIT  = 2'd2;

   // scan modes
   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_WORD = 2'd1;
   localparam logic [1:0] MODE_NUM  = 2'd2;
   localparam logic [1:0] MODE_STR  = 2'd3;

   localparam logic [31:0] INT_MAX_LIT = 32'h7FFF_FFFF;

   // one result word
   typedef struct packed {
      logic [4:0]  kind;
      logic [2:0]  err;
      logic [15:0] line;
      logic        has_idx;
      logic [7:0]  idx;
      logic        new_e;
      logic [1:0]  cls;
      logic        typ;
      logic [31:0] ival;
      logic [7:0]  slen;
      logic        last;
   } tok_type;

   // controller to datapath
   typedef struct packed {
      logic take_byte;   // run the per-byte datapath step
      logic search_rd;   // issue table read at search pointer
      logic search_adv;  // advance search pointer
      logic finish_id;   // resolve word after search
      logic found;       // search hit
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_search; // step produced a word needing lookup
      logic ptr_end;     // search pointer reached entry count
      logic hit;         // compare hit on the registered read
   } sts_type;

   function automatic logic [4:0] punct_code(input logic [7:0] b);
      case (b)
         8'h3B:   punct_code = 5'd0;
         8'h2C:   punct_code = 5'd1;
         8'h7B:   punct_code = 5'd2;
         8'h7D:   punct_code = 5'd3;
         8'h28:   punct_code = 5'd4;
         8'h29:   punct_code = 5'd5;
         8'h2B:   punct_code = 5'd6;
         8'h2D:   punct_code = 5'd7;
         8'h2A:   punct_code = 5'd8;
         8'h2F:   punct_code = 5'd9;
         8'h3D:   punct_code = 5'd10;
         default: punct_code = 5'd31;
      endcase
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      is_digit = (b >= 8'h30) && (b <= 8'h39);
   endfunction

   function automatic logic is_letter(input logic [7:0] b);
      is_letter = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
   endfunction

   // keyword index 0..6, 7 when none
   function automatic logic [2:0] kw_code(input logic [63:0] w);
      case (w)
         64'h0072_6567_6574_6E69: kw_code = 3'd0; // integer
         64'h0000_676E_6972_7473: kw_code = 3'd1; // string
         64'h6E6F_6974_636E_7566: kw_code = 3'd2; // function
         64'h0065_7261_6C63_6564: kw_code = 3'd3; // declare
         64'h0000_6E72_7574_6572: kw_code = 3'd4; // return
         64'h0000_0074_6E69_7270: kw_code = 3'd5; // print
         64'h0000_0000_6E69_616D: kw_code = 3'd6; // main
         default:                 kw_code = 3'd7;
      endcase
   endfunction

endpackage

[hdl/kwl_ram.sv]
// generic ram, one write port and one read port, with registered read
module kwl_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

[hdl/kwl_ctrl.sv]
// controller: byte acceptance and name table search sequencing
module kwl_ctrl
   import kwl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_fire,
   input  logic    out_busy,
   input  sts_type sts,
   output logic    in_ready,
   output cmd_type cmd
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_CMP  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       found_ff, found_in;

   // next state
   always_comb begin
      state_in = state_ff;
      found_in = found_ff;
      cmd      = '0;
      in_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            in_ready      = !out_busy;
            cmd.take_byte = in_fire;
            if (in_fire && sts.need_search) begin
               state_in = ST_READ;
               found_in = 1'b0;
            end
         end
         ST_READ: begin
            if (sts.ptr_end) state_in = ST_DONE;
            else begin
               cmd.search_rd = 1'b1;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (sts.hit) begin
               found_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               cmd.search_adv = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            cmd.finish_id = 1'b1;
            cmd.found     = found_ff;
            state_in      = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         found_ff <= found_in;
      end
   end

   // no byte taken outside idle
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      in_ready |-> state_ff == ST_IDLE) else $error("ready outside idle");
   // done is always followed by idle
   a_done_one: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |=> state_ff == ST_IDLE) else $error("done stuck");
   // compare follows a read
   a_cmp_after: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CMP |-> $past(state_ff) == ST_READ) else $error("bad cmp");
endmodule

[hdl/kwl_dp.sv]
// datapath: scanner state, token building, name table, result queue
module kwl_dp
   import kwl_pkg::*;
#(
   parameter int NAME_BUFFER  = NAME_BUFFER_DEF,
   parameter int STRING_LIMIT = STRING_LIMIT_DEF,
   parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  logic [7:0]  in_byte,
   input  logic        in_eot,
   input  logic [31:0] def_int,
   input  logic        out_ready,
   output logic        out_valid,
   output tok_type     out_tok,
   output logic        out_busy,
   output sts_type     sts
);
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int SW = $clog2(STRING_LIMIT + 1);
   localparam int WORD_MAX = (NAME_BUFFER - 1 < 8) ? NAME_BUFFER - 1 : 8;

   logic [1:0]    mode_ff, mode_in;
   logic [15:0]   line_ff, line_in;
   logic [63:0]   word_ff, word_in;
   logic [3:0]    wlen_ff, wlen_in;
   logic [31:0]   num_ff, num_in;
   logic [SW-1:0] scnt_ff, scnt_in;
   logic [CW-1:0] ecnt_ff, ecnt_in;
   logic          fpend_ff, fpend_in;
   logic          ptype_ff, ptype_in;
   logic          halt_ff, halt_in;
   logic [TABLE_DEPTH-1:0] nvalid_ff, nvalid_in;

   // held items: a word to look up, then a trailing byte step
   logic          hold_word_ff, hold_word_in;
   logic [63:0]   hword_ff, hword_in;
   logic          trail_ff, trail_in;
   logic [7:0]    tbyte_ff, tbyte_in;
   logic          teot_ff, teot_in;
   logic [15:0]   tline_ff, tline_in;

   logic [CW-1:0] ptr_ff, ptr_in;
   logic [63:0]   rd_word;
   logic          rd_vld_ff, rd_vld_in;
   logic          hit;
   logic          need_lookup;

   // two-entry result queue
   tok_type       q_ff [2];
   tok_type       q_in [2];
   logic [1:0]    qn_ff, qn_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;

   kwl_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_names (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (hword_ff),
      .rd_addr (ptr_ff[AW-1:0]),
      .rd_data (rd_word)
   );

   assign hit = rd_vld_ff && (rd_word == hword_ff);
   assign sts = '{need_search: need_lookup, ptr_end: (ptr_ff >= ecnt_ff), hit: hit};
   assign out_valid = (qn_ff != 2'd0);
   assign out_tok = q_ff[0];
   assign out_busy = (qn_ff != 2'd0);

   // combinational next-state step
   always_comb begin
      tok_type t, r0, r1;
      logic [1:0] n;
      logic [7:0] b;
      logic [3:0] d;
      logic [35:0] prod;
      logic [2:0] kw;
      logic [4:0] pc;
      logic flush_w, flush_n, idle_step, eot_pend;
      logic [15:0] ln;

      mode_in = mode_ff; line_in = line_ff; word_in = word_ff; wlen_in = wlen_ff;
      num_in = num_ff; scnt_in = scnt_ff; ecnt_in = ecnt_ff; fpend_in = fpend_ff;
      ptype_in = ptype_ff; halt_in = halt_ff; nvalid_in = nvalid_ff;
      hold_word_in = hold_word_ff; hword_in = hword_ff; trail_in = trail_ff;
      tbyte_in = tbyte_ff; teot_in = teot_ff; tline_in = tline_ff;
      ptr_in = ptr_ff; rd_vld_in = 1'b0;
      q_in[0] = q_ff[0]; q_in[1] = q_ff[1];
      qn_in = qn_ff;
      wr_en = 1'b0; wr_addr = ptr_ff[AW-1:0];
      need_lookup = 1'b0;
      r0 = '0; r1 = '0; n = 2'd0; t = '0;
      b = in_byte; d = '0; prod = '0; kw = 3'd7; pc = 5'd31;
      flush_w = 1'b0; flush_n = 1'b0; idle_step = 1'b0; eot_pend = 1'b0;
      ln = line_ff;

      // pop
      if (out_valid && out_ready) begin
         q_in[0] = q_ff[1];
         qn_in = qn_ff - 2'd1;
      end

      if (cmd.search_rd) rd_vld_in = 1'b1;
      if (cmd.search_adv) ptr_in = ptr_ff + CW'(1);

      if (cmd.take_byte && !halt_ff) begin
         d = in_byte[3:0];
         // byte inside a token
         case (mode_ff)
            MODE_WORD: begin
               if (is_letter(b) || is_digit(b)) begin
                  if (32'(wlen_ff) >= WORD_MAX) begin
                     t = '0; t.kind = TK_ERROR; t.err = ERR_WORD_LONG; t.line = ln;
                     r0 = t; n = 2'd1; halt_in = 1'b1;
                  end else begin
                     word_in = word_ff | (64'(b) << {wlen_ff[2:0], 3'b000});
                     wlen_in = wlen_ff + 4'd1;
                  end
               end else begin
                  mode_in = MODE_IDLE; flush_w = 1'b1; idle_step = 1'b1;
               end
            end
            MODE_NUM: begin
               if (is_digit(b)) begin
                  prod = {4'd0, num_ff} * 36'd10 + 36'(d);
                  num_in = (prod > 36'(INT_MAX_LIT)) ? INT_MAX_LIT : prod[31:0];
               end else begin
                  mode_in = MODE_IDLE; flush_n = 1'b1; idle_step = 1'b1;
               end
            end
            MODE_STR: begin
               if (b == 8'h27) begin
                  mode_in = MODE_IDLE;
                  t = '0; t.line = ln;
                  if (32'(scnt_ff) >= STRING_LIMIT) begin
                     t.kind = TK_ERROR; t.err = ERR_STR_LONG; halt_in = 1'b1;
                  end else if (32'(ecnt_ff) >= TABLE_DEPTH) begin
                     t.kind = TK_ERROR; t.err = ERR_FULL; halt_in = 1'b1;
                  end else begin
                     t.kind = TK_STR_LIT; t.has_idx = 1'b1; t.idx = 8'(ecnt_ff);
                     t.new_e = 1'b1; t.cls = CLS_LIT; t.typ = 1'b1; t.slen = 8'(scnt_ff);
                     ecnt_in = ecnt_ff + CW'(1);
                  end
                  r0 = t; n = 2'd1;
               end else if (b == 8'h0A) begin
                  t = '0; t.kind = TK_ERROR; t.err = ERR_UNTERM; t.line = ln;
                  r0 = t; n = 2'd1; halt_in = 1'b1;
               end else if (32'(scnt_ff) < STRING_LIMIT) begin
                  scnt_in = scnt_ff + SW'(1);
               end
            end
            default: idle_step = 1'b1;
         endcase

         // number flush
         if (flush_n) begin
            t = '0; t.line = ln;
            if (32'(ecnt_ff) >= TABLE_DEPTH) begin
               t.kind = TK_ERROR; t.err = ERR_FULL; halt_in = 1'b1; idle_step = 1'b0;
            end else begin
               t.kind = TK_INT_LIT; t.has_idx = 1'b1; t.idx = 8'(ecnt_ff);
               t.new_e = 1'b1; t.cls = CLS_LIT; t.ival = num_ff;
               ecnt_in = ecnt_ff + CW'(1);
            end
            r0 = t; n = 2'd1;
         end

         // word flush: keyword at once, else defer the byte behind a search
         if (flush_w) begin
            kw = kw_code(word_ff);
            if (kw != 3'd7) begin
               t = '0; t.kind = TK_KW_BASE + 5'(kw); t.line = ln;
               r0 = t; n = 2'd1;
               if (kw == 3'd0) ptype_in = 1'b0;
               if (kw == 3'd1) ptype_in = 1'b1;
               if (kw == 3'd2) fpend_in = 1'b1;
            end else begin
               need_lookup = 1'b1;
               hold_word_in = 1'b1; hword_in = word_ff;
               trail_in = 1'b1; tbyte_in = b; teot_in = in_eot; tline_in = ln;
               ptr_in = '0;
               idle_step = 1'b0;
            end
         end

         // byte between tokens
         if (idle_step && !halt_in) begin
            pc = punct_code(b);
            t = '0; t.line = ln;
            if (b == 8'h0A) begin
               if (line_ff != 16'hFFFF) line_in = line_ff + 16'd1;
            end else if (b == 8'h20 || b == 8'h09 || b == 8'h0B || b == 8'h0C
                         || b == 8'h0D) begin
               t = '0;
            end else if (pc != 5'd31) begin
               t.kind = pc;
               if (n == 2'd0) r0 = t; else r1 = t;
               n = n + 2'd1;
            end else if (b == 8'h27) begin
               mode_in = MODE_STR; scnt_in = '0;
            end else if (is_digit(b)) begin
               mode_in = MODE_NUM; num_in = {28'd0, d};
            end else if (is_letter(b)) begin
               mode_in = MODE_WORD; word_in = {56'd0, b}; wlen_in = 4'd1;
            end else begin
               t.kind = TK_ERROR; t.err = ERR_BAD_BYTE; halt_in = 1'b1;
               if (n == 2'd0) r0 = t; else r1 = t;
               n = n + 2'd1;
            end
         end

         // end of text flush (not when a search is pending)
         if (in_eot && !halt_in && !need_lookup) begin
            eot_pend = 1'b1;
            t = '0; t.line = line_in;
            case (mode_in)
               MODE_WORD: begin
                  kw = kw_code(word_in);
                  if (kw != 3'd7) begin
                     t.kind = TK_KW_BASE + 5'(kw);
                     if (n == 2'd0) r0 = t; else r1 = t;
                     n = n + 2'd1;
                     if (kw == 3'd0) ptype_in = 1'b0;
                     if (kw == 3'd1) ptype_in = 1'b1;
                     if (kw == 3'd2) fpend_in = 1'b1;
                  end else begin
                     need_lookup = 1'b1;
                     hold_word_in = 1'b1; hword_in = word_in;
                     trail_in = 1'b0; tline_in = line_in;
                     ptr_in = '0;
                  end
               end
               MODE_NUM: begin
                  if (32'(ecnt_in) >= TABLE_DEPTH) begin
                     t.kind = TK_ERROR; t.err = ERR_FULL; halt_in = 1'b1;
                  end else begin
                     t.kind = TK_INT_LIT; t.has_idx = 1'b1; t.idx = 8'(ecnt_in);
                     t.new_e = 1'b1; t.cls = CLS_LIT; t.ival = num_in;
                     ecnt_in = ecnt_in + CW'(1);
                  end
                  if (n == 2'd0) r0 = t; else r1 = t;
                  n = n + 2'd1;
               end
               MODE_STR: begin
                  t.kind = TK_ERROR; t.err = ERR_UNTERM; halt_in = 1'b1;
                  if (n == 2'd0) r0 = t; else r1 = t;
                  n = n + 2'd1;
               end
               default: t = '0;
            endcase
            mode_in = MODE_IDLE;
         end
         if (!eot_pend && in_eot && need_lookup) mode_in = MODE_IDLE;

         // mark last and push
         if (n == 2'd1) r0.last = 1'b1;
         if (n == 2'd2) r1.last = 1'b1;
         if (n != 2'd0) begin
            q_in[0] = r0; q_in[1] = r1; qn_in = n;
         end
      end

      // resolve a searched word, then run the held byte
      if (cmd.finish_id) begin
         t = '0; t.kind = TK_IDENT; t.has_idx = 1'b1; t.line = tline_ff;
         hold_word_in = 1'b0;
         if (cmd.found) begin
            t.idx = 8'(ptr_ff);
         end else if (32'(ecnt_ff) >= TABLE_DEPTH) begin
            t = '0; t.kind = TK_ERROR; t.err = ERR_FULL; t.line = tline_ff;
            halt_in = 1'b1;
         end else begin
            wr_en = 1'b1; wr_addr = ecnt_ff[AW-1:0];
            nvalid_in[ecnt_ff[AW-1:0]] = 1'b1;
            t.idx = 8'(ecnt_ff); t.new_e = 1'b1;
            t.cls = fpend_ff ? CLS_FUNC : CLS_VAR; fpend_in = 1'b0;
            t.typ = ptype_ff; t.ival = ptype_ff ? 32'd0 : def_int;
            ecnt_in = ecnt_ff + CW'(1);
         end
         r0 = t; n = 2'd1;
         if (trail_ff && !halt_in) begin
            b = tbyte_ff;
            pc = punct_code(b);
            t = '0; t.line = tline_ff;
            if (b == 8'h0A) begin
               if (line_ff != 16'hFFFF) line_in = line_ff + 16'd1;
            end else if (b == 8'h20 || b == 8'h09 || b == 8'h0B || b == 8'h0C
                         || b == 8'h0D) begin
               t = '0;
            end else if (pc != 5'd31) begin
               t.kind = pc; r1 = t; n = 2'd2;
            end else if (b == 8'h27) begin
               mode_in = MODE_STR; scnt_in = '0;
               if (teot_ff) begin
                  t.kind = TK_ERROR; t.err = ERR_UNTERM; halt_in = 1'b1;
                  r1 = t; n = 2'd2; mode_in = MODE_IDLE;
               end
            end else if (is_digit(b)) begin
               mode_in = MODE_NUM; num_in = {28'd0, b[3:0]};
               if (teot_ff) begin
                  mode_in = MODE_IDLE;
                  t.kind = TK_INT_LIT; t.has_idx = 1'b1; t.idx = 8'(ecnt_in);
                  t.new_e = 1'b1; t.cls = CLS_LIT; t.ival = {28'd0, b[3:0]};
                  if (32'(ecnt_in) >= TABLE_DEPTH) begin
                     t = '0; t.kind = TK_ERROR; t.err = ERR_FULL; t.line = tline_ff;
                     halt_in = 1'b1;
                  end else ecnt_in = ecnt_in + CW'(1);
                  r1 = t; n = 2'd2;
               end
            end else if (is_letter(b)) begin
               // a held letter starts a new word; an end-of-text flag with it is not acted on here
               mode_in = MODE_WORD; word_in = {56'd0, b}; wlen_in = 4'd1;
            end else begin
               t.kind = TK_ERROR; t.err = ERR_BAD_BYTE; halt_in = 1'b1;
               r1 = t; n = 2'd2;
            end
         end
         if (n == 2'd1) r0.last = 1'b1; else r1.last = 1'b1;
         q_in[0] = r0; q_in[1] = r1; qn_in = n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE; line_ff <= 16'd1; word_ff <= '0; wlen_ff <= '0;
         num_ff <= '0; scnt_ff <= '0; ecnt_ff <= '0; fpend_ff <= 1'b0;
         ptype_ff <= 1'b0; halt_ff <= 1'b0; nvalid_ff <= '0;
         hold_word_ff <= 1'b0; trail_ff <= 1'b0; qn_ff <= '0; rd_vld_ff <= 1'b0;
         ptr_ff <= '0;
      end else begin
         mode_ff <= mode_in; line_ff <= line_in; word_ff <= word_in; wlen_ff <= wlen_in;
         num_ff <= num_in; scnt_ff <= scnt_in; ecnt_ff <= ecnt_in; fpend_ff <= fpend_in;
         ptype_ff <= ptype_in; halt_ff <= halt_in; nvalid_ff <= nvalid_in;
         hold_word_ff <= hold_word_in; trail_ff <= trail_in; qn_ff <= qn_in;
         rd_vld_ff <= rd_vld_in && nvalid_ff[ptr_ff[AW-1:0]]; ptr_ff <= ptr_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hword_ff <= hword_in; tbyte_ff <= tbyte_in; teot_ff <= teot_in;
      tline_ff <= tline_in; q_ff[0] <= q_in[0]; q_ff[1] <= q_in[1];
   end

   // queue never over two
   a_q_bound: assert property (@(posedge clock) disable iff (reset)
      qn_ff != 2'd3) else $error("queue overflow");
   // entry count never decreases
   a_ecnt_mono: assert property (@(posedge clock) disable iff (reset)
      ecnt_ff >= $past(ecnt_ff) || $past(reset)) else $error("entry count fell");
   // halt stays set
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff) else $error("halt cleared");
endmodule

[hdl/keyword_lexer_with_symbol_table_top.sv]
// keyword lexer with name table, top level
//  channel  | dir | tdata fields (low bit up)
//  req_     | in  | text_byte[7:0], end_of_text[8]
//  rsp_     | out | token_kind..string_length packed, tlast = last_of_run
//  csr_     | cfg | reg 0 default_int_value at address 0
// a byte is taken only while idle with the two-word queue empty;
// a new or repeated identifier walks the name table, each entry being
// a registered ram read then a compare, so its cost grows with entry count.
// reset is synchronous; the table needs no clearing pass (valid bits).
// rsp_tready low holds results in the queue and stops byte intake.
module keyword_lexer_with_symbol_table_top
   import kwl_pkg::*;
#(
   parameter int NAME_BUFFER  = NAME_BUFFER_DEF,
   parameter int STRING_LIMIT = STRING_LIMIT_DEF,
   parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // text_byte[7:0], end_of_text[8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // token_kind[4:0] error_code[7:5] line_number[23:8] has_index[24]
   // table_index[32:25] new_entry[33] entry_class[35:34] entry_type[36]
   // int_value[68:37] string_length[76:69]
   output logic [79:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam logic [1:0] REG_DEF_INT = 2'd0;

   logic [31:0] def_int_ff;
   cmd_type     cmd;
   sts_type     sts;
   logic        out_busy;
   tok_type     tok;

   // config register
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_DEF_INT) ? def_int_ff : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) def_int_ff <= '0;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == REG_DEF_INT)
         def_int_ff <= csr_pwdata;
   end

   kwl_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_fire  (req_tvalid && req_tready),
      .out_busy (out_busy),
      .sts      (sts),
      .in_ready (req_tready),
      .cmd      (cmd)
   );

   kwl_dp #(
      .NAME_BUFFER (NAME_BUFFER),
      .STRING_LIMIT(STRING_LIMIT),
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .in_byte   (req_tdata[7:0]),
      .in_eot    (req_tdata[8]),
      .def_int   (def_int_ff),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_tok   (tok),
      .out_busy  (out_busy),
      .sts       (sts)
   );

   // pack result word
   assign rsp_tdata = {3'd0, tok.slen, tok.ival, tok.typ, tok.cls, tok.new_e,
                       tok.idx, tok.has_idx, tok.line, tok.err, tok.kind};
   assign rsp_tlast = tok.last;
endmodule
